>>> sv/pls_pkg.sv
// Package: shared types, codes and constants of the passive serial loader.
package pls_pkg;

  localparam int COUNT_BITS_DEF = 16;

  localparam logic [15:0] PULSE_LOW_RST  = 16'd2000;
  localparam logic [15:0] BYTE_COUNT_RST = 16'd32500;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_COUNT = 1'b1;

  // bit positions in the pin image
  localparam int PIN_NCONFIG = 0;
  localparam int PIN_DATA    = 1;
  localparam int PIN_DCLK    = 2;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_PULSE  = 3'd1,
    PH_WAIT   = 3'd2,
    PH_REQ    = 3'd3,
    PH_BIT    = 3'd4,
    PH_FINISH = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    SUB_CLK_LOW  = 2'd0,
    SUB_DATA     = 2'd1,
    SUB_CLK_HIGH = 2'd2
  } subphase_t;

  typedef struct packed {
    logic       command;
    logic       byte_valid;
    logic [7:0] byte_value;
    logic       nstatus_in;
    logic       cdone_in;
  } in_t;

  typedef struct packed {
    logic nconfig_out;
    logic data_out;
    logic dclk_out;
    logic hold_reset;
    logic byte_request;
    logic busy_res;
    logic done_pulse;
    logic load_ok;
  } out_t;

endpackage

>>> sv/pls_core.sv
// Load sequencer: phase machine, counters, shift byte and pin image.
module pls_core #(
  parameter int COUNT_BITS = pls_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  pls_pkg::in_t          item,
  input  logic [COUNT_BITS-1:0] pulse_lim,
  input  logic [COUNT_BITS-1:0] byte_cnt,
  output pls_pkg::out_t         res
);
  import pls_pkg::*;

  phase_t                phase_r, phase_nxt;
  subphase_t             sub_r, sub_nxt;
  logic [COUNT_BITS-1:0] delay_r, delay_nxt;
  logic [COUNT_BITS-1:0] bytes_r, bytes_nxt;
  logic [COUNT_BITS-1:0] bytes_inc;
  logic [2:0]            bit_r, bit_nxt;
  logic [7:0]            shift_r, shift_nxt;
  logic [2:0]            pin_r, pin_nxt;
  logic                  last_r, last_nxt;
  logic                  done;

  assign bytes_inc = bytes_r + COUNT_BITS'(1);

  // next state and datapath
  always_comb begin
    phase_nxt = phase_r;
    sub_nxt   = sub_r;
    delay_nxt = delay_r;
    bytes_nxt = bytes_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    pin_nxt   = pin_r;
    last_nxt  = last_r;
    done      = 1'b0;
    case (phase_r)
      PH_PULSE: begin
        if (delay_r >= pulse_lim) begin
          pin_nxt[PIN_NCONFIG] = 1'b1;
          phase_nxt = PH_WAIT;
        end else begin
          delay_nxt = delay_r + COUNT_BITS'(1);
        end
      end
      PH_WAIT: begin
        if (item.nstatus_in) begin
          bytes_nxt = '0;
          phase_nxt = (byte_cnt == '0) ? PH_FINISH : PH_REQ;
        end
      end
      PH_REQ: begin
        if (item.byte_valid) begin
          shift_nxt = item.byte_value;
          bit_nxt   = 3'd0;
          sub_nxt   = SUB_CLK_LOW;
          phase_nxt = PH_BIT;
        end
      end
      PH_BIT: begin
        case (sub_r)
          SUB_DATA: begin
            pin_nxt[PIN_DATA] = shift_r[0];
            shift_nxt = {1'b0, shift_r[7:1]};
            sub_nxt   = SUB_CLK_HIGH;
          end
          SUB_CLK_HIGH: begin
            pin_nxt[PIN_DCLK] = 1'b1;
            sub_nxt = SUB_CLK_LOW;
            if (bit_r == 3'd7) begin
              bit_nxt   = 3'd0;
              bytes_nxt = bytes_inc;
              phase_nxt = (bytes_inc >= byte_cnt) ? PH_FINISH : PH_REQ;
            end else begin
              bit_nxt = bit_r + 3'd1;
            end
          end
          default: begin
            pin_nxt[PIN_DCLK] = 1'b0;
            sub_nxt = SUB_DATA;
          end
        endcase
      end
      PH_FINISH: begin
        last_nxt  = item.cdone_in;
        done      = 1'b1;
        phase_nxt = PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (item.command) begin
          pin_nxt[PIN_DCLK]    = 1'b0;
          pin_nxt[PIN_NCONFIG] = 1'b0;
          delay_nxt = COUNT_BITS'(1);
          bytes_nxt = '0;
          bit_nxt   = 3'd0;
          sub_nxt   = SUB_CLK_LOW;
          phase_nxt = PH_PULSE;
        end
      end
    endcase
  end

  // result word, taken from the updated state
  always_comb begin
    res.nconfig_out  = pin_nxt[PIN_NCONFIG];
    res.data_out     = pin_nxt[PIN_DATA];
    res.dclk_out     = pin_nxt[PIN_DCLK];
    res.hold_reset   = (phase_nxt != PH_IDLE);
    res.byte_request = (phase_nxt == PH_REQ);
    res.busy_res     = (phase_nxt != PH_IDLE);
    res.done_pulse   = done;
    res.load_ok      = last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      sub_r   <= SUB_CLK_LOW;
      delay_r <= '0;
      bytes_r <= '0;
      bit_r   <= 3'd0;
      shift_r <= 8'd0;
      pin_r   <= 3'b001;
      last_r  <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      sub_r   <= sub_nxt;
      delay_r <= delay_nxt;
      bytes_r <= bytes_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      pin_r   <= pin_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

>>> sv/pld_passive_serial_loader.sv
// Top level: word handshakes, configuration registers and the load sequencer.
//
// Passive serial configuration loader. Every input word is one tick of the
// pin port and yields exactly one result word holding the pin levels and
// status after that tick. A word with command set while idle starts a load:
// the neighbouring controller is held in reset, nCONFIG and DCLK go low for
// pulse_low_ticks ticks (the start tick counts), nCONFIG is released and the
// loader waits for nSTATUS high. It then requests load_byte_count bytes via
// byte_request/byte_valid and shifts each out LSB first in three ticks per
// bit: DCLK low, DATA set, DCLK high. The last tick samples the CDONE pin into
// load_ok and pulses done_pulse. Throughput is one word per clock while
// out_stall is low; a word passes the input register, then the result
// register, and the sequencer state advances once per word as it moves
// between the two. Write the configuration registers only while no word is
// in flight; both are read live and truncated or zero-extended to
// COUNT_BITS bits.
module pld_passive_serial_loader #(
  parameter int COUNT_BITS = pls_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  pls_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output pls_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                    cfg_data
);
  import pls_pkg::*;

  logic [15:0] pulse_low_r;
  logic [15:0] byte_count_r;

  logic        s1_valid_r;
  in_t         s1_data_r;
  logic        s1_adv;
  logic        out_valid_r;
  out_t        out_data_r;
  out_t        core_res;

  logic [COUNT_BITS-1:0] pulse_lim;
  logic [COUNT_BITS-1:0] byte_cnt;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_low_r  <= PULSE_LOW_RST;
      byte_count_r <= BYTE_COUNT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PULSE_LOW:  pulse_low_r  <= cfg_data;
        CFG_BYTE_COUNT: byte_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Fit the 16-bit registers to the counter width.
  assign pulse_lim = COUNT_BITS'(pulse_low_r);
  assign byte_cnt  = COUNT_BITS'(byte_count_r);

  // Advance the held word into the result register when that is free
  // or being drained this cycle.
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  // Stall the input only when the held word cannot move on.
  assign in_stall = s1_valid_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
  end

  pls_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (s1_adv),
    .item     (s1_data_r),
    .pulse_lim(pulse_lim),
    .byte_cnt (byte_cnt),
    .res      (core_res)
  );

  // Result register: load on advance, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= core_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
